// ===== design/scfr_pkg.sv =====
// scfr_pkg: constants, salt table and crc-8 byte step for the salted crc-8
// frame receiver
// no dependencies
package scfr_pkg;

  localparam int BUFFER_BYTES = 64;
  localparam int CRC_OFFSET   = 2;
  localparam int MSGID_OFFSET = 6;

  localparam int ADDR_W = $clog2(BUFFER_BYTES);
  localparam int IDX_W  = $clog2(BUFFER_BYTES + 1);

  localparam logic [7:0]  CRC_POLY       = 8'h31;
  localparam logic [7:0]  CRC_INIT       = 8'hFF;
  localparam logic [7:0]  HDR_FIRST      = 8'hA5;
  localparam logic [7:0]  HDR_SECOND     = 8'h44;
  localparam logic [7:0]  FRAME_OVERHEAD = 8'd7;
  localparam logic [7:0]  SALT_COUNT     = 8'd25;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd20;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef logic [7:0] byte_t;

  // salt for a message id below SALT_COUNT
  function automatic byte_t salt_of(input logic [4:0] id);
    byte_t s;
    case (id)
      5'd0:  s = 8'd10;
      5'd1:  s = 8'd12;
      5'd2:  s = 8'd15;
      5'd3:  s = 8'd18;
      5'd4:  s = 8'd33;
      5'd5:  s = 8'd134;
      5'd6:  s = 8'd65;
      5'd7:  s = 8'd234;
      5'd8:  s = 8'd98;
      5'd9:  s = 8'd68;
      5'd10: s = 8'd45;
      5'd11: s = 8'd234;
      5'd12: s = 8'd54;
      5'd13: s = 8'd57;
      5'd14: s = 8'd21;
      5'd15: s = 8'd61;
      5'd16: s = 8'd201;
      5'd17: s = 8'd69;
      5'd18: s = 8'd5;
      5'd19: s = 8'd241;
      5'd20: s = 8'd168;
      5'd21: s = 8'd23;
      5'd22: s = 8'd79;
      5'd23: s = 8'd62;
      5'd24: s = 8'd77;
      default: s = 8'd0;
    endcase
    return s;
  endfunction

  // msb-first crc-8 over one byte, no reflection
  function automatic byte_t crc8_byte(input byte_t crc_in, input byte_t data);
    byte_t c;
    c = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== design/salted_crc8_frame_receiver_top.sv =====
// salted_crc8_frame_receiver_top: header hunt, frame store, salted crc-8 check
// and frame replay; depends on scfr_pkg
//
//   channel  | direction | signals                               | note
//   in_      | input     | in_valid/in_ready, opcode, data_byte  | byte or tick item
//   out_     | output    | out_valid/out_ready, frame_byte, last | one item per frame byte
//   cfg_     | input     | cfg_we, cfg_wdata                     | timeout_ticks, no wait
//
// a byte or tick item is taken whenever in_valid is high while the sequencer
// is idle; the item that completes a good-id frame keeps in_ready low while the
// crc unit walks the frame store, reading each frame byte and then stepping the
// crc with it, then compares with the received crc; on a match, replay reads
// each byte and loads the output register, waiting while the output register
// is full and out_ready stays low
// a crc mismatch returns the sequencer to idle after the compare, with no replay
// rst_n is synchronous, active low; the frame store has no reset
module salted_crc8_frame_receiver_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_frame_byte,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int AW = scfr_pkg::ADDR_W;
  localparam int IW = scfr_pkg::IDX_W;

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;  // taking items
  localparam logic [2:0] S_CRD  = 3'd1;  // crc pass: read store
  localparam logic [2:0] S_CUP  = 3'd2;  // crc pass: step crc
  localparam logic [2:0] S_CHK  = 3'd3;  // compare with received crc
  localparam logic [2:0] S_ERD  = 3'd4;  // replay: read store
  localparam logic [2:0] S_EWR  = 3'd5;  // replay: load output register

  logic [2:0]  state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;      // frame bytes held, 0 while hunting
  logic [IW-1:0] len_r, len_nxt;      // total frame length
  logic [15:0] idle_r, idle_nxt;
  logic [15:0] timeout_r;
  logic [7:0]  rxcrc_r, rxcrc_nxt;
  logic [7:0]  msgid_r, msgid_nxt;
  logic [7:0]  salt_r, salt_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [7:0]  rdata_r;

  logic        ov_r, ov_nxt;
  logic [7:0]  ob_r, ob_nxt;
  logic        ol_r, ol_nxt;

  scfr_pkg::byte_t mem [scfr_pkg::BUFFER_BYTES];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;

  logic          accept;
  logic [IW-1:0] idx_inc;
  logic [8:0]    total_w;
  logic [7:0]    msgid_now;
  logic [7:0]    rxcrc_now;
  logic [7:0]    cur_byte;
  logic          at_end;

  assign in_ready       = (state_r == S_IDLE);
  assign accept         = in_valid && in_ready;
  assign out_valid      = ov_r;
  assign out_frame_byte = ob_r;
  assign out_last       = ol_r;

  assign idx_inc = idx_r + IW'(1);
  assign total_w = 9'(scfr_pkg::FRAME_OVERHEAD) + {1'b0, in_data_byte};

  // the offsets may land on the byte being taken now
  assign msgid_now = (idx_r == IW'(scfr_pkg::MSGID_OFFSET)) ? in_data_byte : msgid_r;
  assign rxcrc_now = (idx_r == IW'(scfr_pkg::CRC_OFFSET)) ? in_data_byte : rxcrc_r;

  // the crc slot reads back as the salt
  assign cur_byte = (ptr_r == AW'(scfr_pkg::CRC_OFFSET)) ? salt_r : rdata_r;
  assign at_end   = ({1'b0, ptr_r} == IW'(len_r - IW'(1)));

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    idle_nxt  = idle_r;
    rxcrc_nxt = rxcrc_r;
    msgid_nxt = msgid_r;
    salt_nxt  = salt_r;
    crc_nxt   = crc_r;
    ptr_nxt   = ptr_r;
    ov_nxt    = ov_r;
    ob_nxt    = ob_r;
    ol_nxt    = ol_r;
    mem_we    = 1'b0;
    mem_waddr = idx_r[AW-1:0];

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_opcode == scfr_pkg::OP_TICK) begin
            // saturating idle count, drop partial frame past the timeout
            if (idle_r != 16'hFFFF) begin
              idle_nxt = idle_r + 16'd1;
            end
            if (idx_r != '0 && idle_nxt > timeout_r) begin
              idx_nxt = '0;
            end
          end else begin
            idle_nxt = '0;
            if (idx_r == '0) begin
              if (in_data_byte == scfr_pkg::HDR_FIRST) begin
                mem_we  = 1'b1;
                idx_nxt = IW'(1);
              end
            end else if (idx_r == IW'(1)) begin
              if (in_data_byte == scfr_pkg::HDR_SECOND) begin
                mem_we  = 1'b1;
                idx_nxt = IW'(2);
              end else begin
                idx_nxt = '0;
              end
            end else if (idx_r >= IW'(scfr_pkg::BUFFER_BYTES)) begin
              idx_nxt = '0;
            end else begin
              mem_we = 1'b1;
              if (idx_r == IW'(scfr_pkg::CRC_OFFSET)) begin
                rxcrc_nxt = in_data_byte;
              end
              if (idx_r == IW'(scfr_pkg::MSGID_OFFSET)) begin
                msgid_nxt = in_data_byte;
              end
              if (idx_r < IW'(3)) begin
                idx_nxt = idx_inc;
              end else if (idx_r == IW'(3)) begin
                // length byte
                if (total_w > 9'(scfr_pkg::BUFFER_BYTES)) begin
                  idx_nxt = '0;
                end else begin
                  len_nxt = IW'(total_w);
                  idx_nxt = idx_inc;
                end
              end else if (idx_inc == len_r) begin
                // frame complete
                idx_nxt   = '0;
                rxcrc_nxt = rxcrc_now;
                if (msgid_now < scfr_pkg::SALT_COUNT) begin
                  salt_nxt  = scfr_pkg::salt_of(msgid_now[4:0]);
                  crc_nxt   = scfr_pkg::CRC_INIT;
                  ptr_nxt   = '0;
                  state_nxt = S_CRD;
                end
              end else begin
                idx_nxt = idx_inc;
              end
            end
          end
        end
      end
      S_CRD: begin
        state_nxt = S_CUP;
      end
      S_CUP: begin
        crc_nxt = scfr_pkg::crc8_byte(crc_r, cur_byte);
        if (at_end) begin
          state_nxt = S_CHK;
        end else begin
          ptr_nxt   = ptr_r + AW'(1);
          state_nxt = S_CRD;
        end
      end
      S_CHK: begin
        ptr_nxt = '0;
        if (crc_r == rxcrc_r) begin
          state_nxt = S_ERD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ERD: begin
        state_nxt = S_EWR;
      end
      S_EWR: begin
        // load once the output register is free or being taken
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          ob_nxt = cur_byte;
          ol_nxt = at_end;
          if (at_end) begin
            state_nxt = S_IDLE;
          end else begin
            ptr_nxt   = ptr_r + AW'(1);
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_data_byte;
    end
    rdata_r <= mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      idx_r     <= '0;
      idle_r    <= '0;
      timeout_r <= scfr_pkg::TIMEOUT_RESET;
      ov_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      idle_r  <= idle_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    len_r   <= len_nxt;
    rxcrc_r <= rxcrc_nxt;
    msgid_r <= msgid_nxt;
    salt_r  <= salt_nxt;
    crc_r   <= crc_nxt;
    ptr_r   <= ptr_nxt;
    ob_r    <= ob_nxt;
    ol_r    <= ol_nxt;
  end

endmodule
